[src/i2a_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes, constants and the control store of the number
// formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int MAX_DIGITS_DEF  = 32;
  localparam int RADIX_MAX_DEF   = 16;
  localparam int ADDR_DIGITS_DEF = 12;

  localparam int ACTION_W  = 2;
  localparam int VALUE_W   = 64;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;
  localparam int RADIX_W   = 5;
  localparam int WORK_W    = 48;
  localparam int DIV_W     = 32;
  localparam int DIV_STEPS = DIV_W / 8;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int PC_W      = 5;

  localparam logic [ACTION_W-1:0] MODE_SIGNED   = 2'd0;
  localparam logic [ACTION_W-1:0] MODE_UNSIGNED = 2'd1;
  localparam logic [ACTION_W-1:0] MODE_RADIX    = 2'd2;
  localparam logic [ACTION_W-1:0] MODE_POINTER  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HI = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] DEC_BASE    = 5'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_X      = 8'h78;
  localparam logic [CHAR_W-1:0] ASCII_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] ASCII_N      = 8'h6e;
  localparam logic [CHAR_W-1:0] ASCII_I      = 8'h69;
  localparam logic [CHAR_W-1:0] ASCII_L      = 8'h6c;
  localparam logic [CHAR_W-1:0] ASCII_RPAREN = 8'h29;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_EMIT_CONST,
    OP_DIV_STEP,
    OP_STORE_DIGIT,
    OP_PTR_DIGIT,
    OP_RD_FIRST,
    OP_EMIT_DIGIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_ACCEPT,
    C_IS_PTR,
    C_NOT_NEG,
    C_IS_NIL,
    C_DIV_MORE,
    C_MORE_DIGITS,
    C_PTR_MORE,
    C_IDX_NZ
  } cond_e;

  typedef struct packed {
    op_e              op;
    logic             hold;
    cond_e            cond;
    logic [PC_W-1:0]  target;
    logic [CHAR_W-1:0] chr;
    logic             last;
  } uword_t;

  localparam logic [PC_W-1:0] L_WAIT     = 5'd0;
  localparam logic [PC_W-1:0] L_DISPATCH = 5'd1;
  localparam logic [PC_W-1:0] L_SIGN     = 5'd2;
  localparam logic [PC_W-1:0] L_MINUS    = 5'd3;
  localparam logic [PC_W-1:0] L_DIV      = 5'd4;
  localparam logic [PC_W-1:0] L_STORE    = 5'd5;
  localparam logic [PC_W-1:0] L_RD_FIRST = 5'd6;
  localparam logic [PC_W-1:0] L_EMIT     = 5'd7;
  localparam logic [PC_W-1:0] L_DONE     = 5'd8;
  localparam logic [PC_W-1:0] L_PTR      = 5'd9;
  localparam logic [PC_W-1:0] L_PTR_0    = 5'd10;
  localparam logic [PC_W-1:0] L_PTR_X    = 5'd11;
  localparam logic [PC_W-1:0] L_PTR_DIG  = 5'd12;
  localparam logic [PC_W-1:0] L_PTR_END  = 5'd13;
  localparam logic [PC_W-1:0] L_NIL_0    = 5'd14;
  localparam logic [PC_W-1:0] L_NIL_1    = 5'd15;
  localparam logic [PC_W-1:0] L_NIL_2    = 5'd16;
  localparam logic [PC_W-1:0] L_NIL_3    = 5'd17;
  localparam logic [PC_W-1:0] L_NIL_4    = 5'd18;

  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, hold: 1'b0, cond: C_ALWAYS, target: L_WAIT,
          chr: '0, last: 1'b0};
    unique case (pc)
      L_WAIT: begin
        w.op = OP_LOAD; w.cond = C_NOT_ACCEPT; w.target = L_WAIT;
      end
      L_DISPATCH: begin
        w.cond = C_IS_PTR; w.target = L_PTR;
      end
      L_SIGN: begin
        w.cond = C_NOT_NEG; w.target = L_DIV;
      end
      L_MINUS: begin
        w.op = OP_EMIT_CONST; w.hold = 1'b1; w.cond = C_NEVER; w.chr = ASCII_MINUS;
      end
      L_DIV: begin
        w.op = OP_DIV_STEP; w.cond = C_DIV_MORE; w.target = L_DIV;
      end
      L_STORE: begin
        w.op = OP_STORE_DIGIT; w.cond = C_MORE_DIGITS; w.target = L_DIV;
      end
      L_RD_FIRST: begin
        w.op = OP_RD_FIRST; w.cond = C_NEVER;
      end
      L_EMIT: begin
        w.op = OP_EMIT_DIGIT; w.hold = 1'b1; w.cond = C_IDX_NZ; w.target = L_EMIT;
      end
      L_DONE: begin
        w.cond = C_ALWAYS; w.target = L_WAIT;
      end
      L_PTR: begin
        w.cond = C_IS_NIL; w.target = L_NIL_0;
      end
      L_PTR_0: begin
        w.op = OP_EMIT_CONST; w.hold = 1'b1; w.cond = C_NEVER; w.chr = ASCII_ZERO;
      end
      L_PTR_X: begin
        w.op = OP_EMIT_CONST; w.hold = 1'b1; w.cond = C_NEVER; w.chr = ASCII_X;
      end
      L_PTR_DIG: begin
        w.op = OP_PTR_DIGIT; w.cond = C_PTR_MORE; w.target = L_PTR_DIG;
      end
      L_PTR_END: begin
        w.cond = C_ALWAYS; w.target = L_RD_FIRST;
      end
      L_NIL_0: begin
        w.op = OP_EMIT_CONST; w.hold = 1'b1; w.cond = C_NEVER; w.chr = ASCII_LPAREN;
      end
      L_NIL_1: begin
        w.op = OP_EMIT_CONST; w.hold = 1'b1; w.cond = C_NEVER; w.chr = ASCII_N;
      end
      L_NIL_2: begin
        w.op = OP_EMIT_CONST; w.hold = 1'b1; w.cond = C_NEVER; w.chr = ASCII_I;
      end
      L_NIL_3: begin
        w.op = OP_EMIT_CONST; w.hold = 1'b1; w.cond = C_NEVER; w.chr = ASCII_L;
      end
      L_NIL_4: begin
        w.op = OP_EMIT_CONST; w.hold = 1'b1; w.cond = C_ALWAYS; w.target = L_WAIT;
        w.chr = ASCII_RPAREN; w.last = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = L_WAIT;
      end
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] table_char(input logic [63:0] lo,
                                                   input logic [63:0] hi,
                                                   input logic [3:0]  d);
    logic [63:0] row;
    row = d[3] ? hi : lo;
    return row[{d[2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

[src/i2a_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_if
// Valid/ready channels of the number formatter: number in, characters out,
// register writes.
// ----------------------------------------------------------------------------
interface i2a_in_if;
  logic                          valid;
  logic                          ready;
  logic [i2a_pkg::ACTION_W-1:0]  action;
  logic [i2a_pkg::VALUE_W-1:0]   value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface i2a_out_if;
  logic                        valid;
  logic                        ready;
  logic [i2a_pkg::CHAR_W-1:0]  char_out;
  logic                        last;

  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

interface i2a_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [i2a_pkg::CFG_IDX_W-1:0]  index;
  logic [i2a_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/integer_to_ascii_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Formats one number as ASCII characters, most significant first, in signed
// decimal, unsigned decimal, table radix or pointer hex form.
// ----------------------------------------------------------------------------
// One number is taken at a time; the input is ready only while the control
// program waits for work. A decimal or radix number is accepted and
// dispatched, a minus sign is emitted if needed, then each digit is found by
// a long division that retires 8 dividend bits per cycle and is then stored;
// the characters then stream out, one per cycle when the sink keeps up. A
// pointer streams "0x" and its ADDR_DIGITS digits, or "(nil)". Digits
// wait in a MAX_DIGITS deep buffer read through a registered port, so the
// output is one character behind each read.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits #(
  parameter int MAX_DIGITS  = i2a_pkg::MAX_DIGITS_DEF,
  parameter int RADIX_MAX   = i2a_pkg::RADIX_MAX_DEF,
  parameter int ADDR_DIGITS = i2a_pkg::ADDR_DIGITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  i2a_in_if.sink           in_i,
  i2a_out_if.source        out_o,
  i2a_cfg_if.sink          cfg_i
);

  localparam int IDX_W   = $clog2(MAX_DIGITS);
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int PTR_LEN = (ADDR_DIGITS < MAX_DIGITS) ? ADDR_DIGITS : MAX_DIGITS;

  logic [i2a_pkg::RADIX_W-1:0]   radix_q;
  logic [63:0]                   chars_lo_q, chars_hi_q;

  logic [i2a_pkg::PC_W-1:0]      pc_q, pc_d;
  logic [i2a_pkg::ACTION_W-1:0]  action_q, action_d;
  logic                          neg_q, neg_d;
  logic                          tab_q, tab_d;
  logic [i2a_pkg::RADIX_W-1:0]   base_q, base_d;
  logic [i2a_pkg::WORK_W-1:0]    work_q, work_d;
  logic [3:0]                    rem_q, rem_d;
  logic [i2a_pkg::STEP_W-1:0]    step_q, step_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic                          out_valid_q, out_valid_d;
  logic [i2a_pkg::CHAR_W-1:0]    out_char_q, out_char_d;
  logic                          out_last_q, out_last_d;

  logic [i2a_pkg::CHAR_W-1:0]    mem [MAX_DIGITS];
  logic [i2a_pkg::CHAR_W-1:0]    rd_q;
  logic                          mem_we, rd_en;
  logic [IDX_W-1:0]              mem_waddr, rd_addr;
  logic [i2a_pkg::CHAR_W-1:0]    mem_wdata;

  i2a_pkg::uword_t               uw;
  logic                          in_fire, out_free, stall, cond_true;
  logic [CNT_W:0]                cnt_inc;
  logic [31:0]                   low32, mag32;
  logic                          in_neg;
  logic [i2a_pkg::RADIX_W-1:0]   radix_clamped;
  logic [4:0]                    div_r;
  logic [7:0]                    div_q;

  assign uw        = i2a_pkg::ucode_rom(pc_q);
  assign in_i.ready = (uw.op == i2a_pkg::OP_LOAD);
  assign in_fire   = in_i.valid & in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign stall     = uw.hold && !out_free;
  assign cnt_inc   = {1'b0, cnt_q} + 1'b1;

  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.char_out = out_char_q;
  assign out_o.last    = out_last_q;

  assign low32  = in_i.value[31:0];
  assign in_neg = (in_i.action == i2a_pkg::MODE_SIGNED) && low32[31];
  assign mag32  = in_neg ? (32'd0 - low32) : low32;

  always_comb begin
    if (radix_q < i2a_pkg::RADIX_MIN) begin
      radix_clamped = i2a_pkg::RADIX_MIN;
    end else if (radix_q > i2a_pkg::RADIX_W'(RADIX_MAX)) begin
      radix_clamped = i2a_pkg::RADIX_W'(RADIX_MAX);
    end else begin
      radix_clamped = radix_q;
    end
  end

  // one byte of restoring long division, remainder carried between bytes
  always_comb begin
    div_r = (step_q == '0) ? 5'd0 : {1'b0, rem_q};
    div_q = '0;
    for (int b = 7; b >= 0; b--) begin
      div_r = {div_r[3:0], work_q[i2a_pkg::DIV_W-8+b]};
      if (div_r >= base_q) begin
        div_r    = div_r - base_q;
        div_q[b] = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (uw.cond)
      i2a_pkg::C_NEVER:       cond_true = 1'b0;
      i2a_pkg::C_ALWAYS:      cond_true = 1'b1;
      i2a_pkg::C_NOT_ACCEPT:  cond_true = !in_fire;
      i2a_pkg::C_IS_PTR:      cond_true = (action_q == i2a_pkg::MODE_POINTER);
      i2a_pkg::C_NOT_NEG:     cond_true = !neg_q;
      i2a_pkg::C_IS_NIL:      cond_true = (work_q == '0);
      i2a_pkg::C_DIV_MORE:    cond_true = (step_q != i2a_pkg::STEP_W'(i2a_pkg::DIV_STEPS - 1));
      i2a_pkg::C_MORE_DIGITS: cond_true = (work_q != '0) && (cnt_inc < (CNT_W+1)'(MAX_DIGITS));
      i2a_pkg::C_PTR_MORE:    cond_true = (cnt_inc < (CNT_W+1)'(PTR_LEN));
      i2a_pkg::C_IDX_NZ:      cond_true = (idx_q != '0);
      default:                cond_true = 1'b0;
    endcase
  end

  always_comb begin
    pc_d        = stall ? pc_q : (cond_true ? uw.target : pc_q + 1'b1);
    action_d    = action_q;
    neg_d       = neg_q;
    tab_d       = tab_q;
    base_d      = base_q;
    work_d      = work_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[IDX_W-1:0];
    mem_wdata   = '0;
    rd_en       = 1'b0;
    rd_addr     = idx_q - 1'b1;

    if (!stall) begin
      unique case (uw.op)
        i2a_pkg::OP_LOAD: begin
          if (in_fire) begin
            action_d = in_i.action;
            neg_d    = in_neg;
            tab_d    = (in_i.action == i2a_pkg::MODE_RADIX);
            base_d   = (in_i.action == i2a_pkg::MODE_RADIX) ? radix_clamped
                                                            : i2a_pkg::DEC_BASE;
            cnt_d    = '0;
            step_d   = '0;
            if (in_i.action == i2a_pkg::MODE_POINTER) begin
              work_d = in_i.value[i2a_pkg::WORK_W-1:0];
            end else begin
              work_d = {(i2a_pkg::WORK_W - 32)'(0), mag32};
            end
          end
        end
        i2a_pkg::OP_EMIT_CONST: begin
          out_valid_d = 1'b1;
          out_char_d  = uw.chr;
          out_last_d  = uw.last;
        end
        i2a_pkg::OP_DIV_STEP: begin
          work_d = {(i2a_pkg::WORK_W - i2a_pkg::DIV_W)'(0),
                    work_q[i2a_pkg::DIV_W-9:0], div_q};
          rem_d  = div_r[3:0];
          step_d = step_q + 1'b1;
        end
        i2a_pkg::OP_STORE_DIGIT: begin
          mem_we    = 1'b1;
          mem_wdata = tab_q ? i2a_pkg::table_char(chars_lo_q, chars_hi_q, rem_q)
                            : i2a_pkg::ASCII_ZERO + {4'b0000, rem_q};
          cnt_d     = cnt_q + 1'b1;
        end
        i2a_pkg::OP_PTR_DIGIT: begin
          mem_we    = 1'b1;
          mem_wdata = i2a_pkg::table_char(chars_lo_q, chars_hi_q, work_q[3:0]);
          work_d    = {4'b0000, work_q[i2a_pkg::WORK_W-1:4]};
          cnt_d     = cnt_q + 1'b1;
        end
        i2a_pkg::OP_RD_FIRST: begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(cnt_q - 1'b1);
          idx_d   = IDX_W'(cnt_q - 1'b1);
        end
        i2a_pkg::OP_EMIT_DIGIT: begin
          out_valid_d = 1'b1;
          out_char_d  = rd_q;
          out_last_d  = (idx_q == '0);
          rd_en       = 1'b1;
          idx_d       = idx_q - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= i2a_pkg::RADIX_RESET;
      chars_lo_q <= '0;
      chars_hi_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        i2a_pkg::REG_RADIX:    radix_q    <= cfg_i.data[i2a_pkg::RADIX_W-1:0];
        i2a_pkg::REG_CHARS_LO: chars_lo_q <= cfg_i.data;
        i2a_pkg::REG_CHARS_HI: chars_hi_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= i2a_pkg::L_WAIT;
      action_q    <= i2a_pkg::MODE_SIGNED;
      neg_q       <= 1'b0;
      tab_q       <= 1'b0;
      base_q      <= i2a_pkg::DEC_BASE;
      work_q      <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      action_q    <= action_d;
      neg_q       <= neg_d;
      tab_q       <= tab_d;
      base_q      <= base_d;
      work_q      <= work_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

[tb/tb_integer_to_ascii_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_digits
// Self-checking bench for the number formatter. A short directed table covers
// the field extremes, every mode, the nil pointer, radix clamping and ignored
// upper bits. Random numbers follow across several register settings. Every
// character beat is checked against table text or an in-bench formatter.
// Both sides pause at random, and the character sink once holds off long.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_digits;

  localparam int HOLD_AT     = 250;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 22;

  typedef struct packed {
    logic [i2a_pkg::CHAR_W-1:0] chr;
    logic                       last;
  } char_beat_t;

  typedef struct {
    bit          is_write;
    logic [1:0]  code;
    logic [63:0] data;
    string       text;
  } step_t;

  logic clk;
  logic rst_n;

  i2a_in_if  in_ch ();
  i2a_out_if out_ch ();
  i2a_cfg_if cfg_ch ();

  integer_to_ascii_digits dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  logic [i2a_pkg::RADIX_W-1:0]   radix_q   = i2a_pkg::RADIX_RESET;
  logic [i2a_pkg::CFG_DAT_W-1:0] glyphs_lo = '0;
  logic [i2a_pkg::CFG_DAT_W-1:0] glyphs_hi = '0;

  char_beat_t pending_chars [$];
  int mismatches   = 0;
  int numbers_sent = 0;
  int reg_writes   = 0;
  int beats_seen   = 0;
  int quiet_cycles = 0;
  int in_calm      = 0;
  int cfg_calm     = 0;
  bit held_off     = 1'b0;

  step_t plan [32] = '{
    '{1'b0, i2a_pkg::MODE_SIGNED,   64'h0000_0000_0000_0000, "0"},
    '{1'b0, i2a_pkg::MODE_RADIX,    64'h0000_0000_0000_0000, ""},
    '{1'b0, i2a_pkg::MODE_RADIX,    64'hFFFF_FFFF_0123_4567, ""},
    '{1'b0, i2a_pkg::MODE_POINTER,  64'h0000_0000_0000_0000, "(nil)"},
    '{1'b0, i2a_pkg::MODE_POINTER,  64'hFFFF_0000_0000_0000, "(nil)"},
    '{1'b1, i2a_pkg::REG_CHARS_LO,  64'h3736_3534_3332_3130, ""},
    '{1'b1, i2a_pkg::REG_CHARS_HI,  64'h6665_6463_6261_3938, ""},
    '{1'b0, i2a_pkg::MODE_SIGNED,   64'h0000_0000_8000_0000, "-2147483648"},
    '{1'b0, i2a_pkg::MODE_SIGNED,   64'h0000_0000_FFFF_FFFF, "-1"},
    '{1'b0, i2a_pkg::MODE_SIGNED,   64'h0000_0000_7FFF_FFFF, "2147483647"},
    '{1'b0, i2a_pkg::MODE_SIGNED,   64'hFFFF_FFFF_0000_0005, "5"},
    '{1'b0, i2a_pkg::MODE_SIGNED,   64'h0000_0000_8000_0001, ""},
    '{1'b0, i2a_pkg::MODE_UNSIGNED, 64'h0000_0000_FFFF_FFFF, "4294967295"},
    '{1'b0, i2a_pkg::MODE_UNSIGNED, 64'hFFFF_FFFF_0000_0000, "0"},
    '{1'b0, i2a_pkg::MODE_UNSIGNED, 64'h1234_5678_9ABC_DEF0, "2596069104"},
    '{1'b0, i2a_pkg::MODE_RADIX,    64'h0000_0000_FFFF_FFFF, "ffffffff"},
    '{1'b0, i2a_pkg::MODE_POINTER,  64'hFFFF_FFFF_FFFF_FFFF, "0xffffffffffff"},
    '{1'b0, i2a_pkg::MODE_POINTER,  64'h0000_0000_0000_0001, "0x000000000001"},
    '{1'b1, i2a_pkg::REG_RADIX,     64'd2,                   ""},
    '{1'b0, i2a_pkg::MODE_RADIX,    64'h0000_0000_FFFF_FFFF,
      "11111111111111111111111111111111"},
    '{1'b0, i2a_pkg::MODE_RADIX,    64'h0000_0000_0000_0000, "0"},
    '{1'b1, i2a_pkg::REG_RADIX,     64'd0,                   ""},
    '{1'b0, i2a_pkg::MODE_RADIX,    64'h0000_0000_0000_0005, "101"},
    '{1'b1, i2a_pkg::REG_RADIX,     64'd1,                   ""},
    '{1'b0, i2a_pkg::MODE_RADIX,    64'h0000_0000_8000_0000, ""},
    '{1'b1, i2a_pkg::REG_RADIX,     64'd31,                  ""},
    '{1'b0, i2a_pkg::MODE_RADIX,    64'h0000_0000_DEAD_BEEF, "deadbeef"},
    '{1'b1, i2a_pkg::REG_RADIX,     64'd17,                  ""},
    '{1'b0, i2a_pkg::MODE_RADIX,    64'h0000_0000_0000_CAFE, "cafe"},
    '{1'b1, i2a_pkg::REG_RADIX,     64'd10,                  ""},
    '{1'b0, i2a_pkg::MODE_RADIX,    64'h0000_0000_8000_0000, "2147483648"},
    '{1'b0, i2a_pkg::MODE_POINTER,  64'h0000_8000_0000_0000, "0x800000000000"}
  };

  logic [i2a_pkg::RADIX_W-1:0] radix_corners [6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [i2a_pkg::CHAR_W-1:0] glyph(input logic [3:0] d);
    logic [127:0] row;
    row = {glyphs_hi, glyphs_lo};
    return row[d*8 +: i2a_pkg::CHAR_W];
  endfunction

  function automatic void format_number(input logic [i2a_pkg::ACTION_W-1:0] mode,
                                        input logic [i2a_pkg::VALUE_W-1:0]  num);
    logic [i2a_pkg::CHAR_W-1:0] text [$];
    logic [i2a_pkg::CHAR_W-1:0] digs [$];
    logic [31:0]                mag;
    logic [i2a_pkg::WORK_W-1:0] rest;
    logic [i2a_pkg::WORK_W-1:0] d;
    logic [i2a_pkg::WORK_W-1:0] base;
    bit                         by_table;
    mag      = num[31:0];
    rest     = '0;
    base     = i2a_pkg::WORK_W'(i2a_pkg::DEC_BASE);
    by_table = 1'b0;
    case (mode)
      i2a_pkg::MODE_SIGNED: begin
        if (mag[31]) begin
          text.push_back(i2a_pkg::ASCII_MINUS);
          mag = -mag;
        end
        rest = i2a_pkg::WORK_W'(mag);
      end
      i2a_pkg::MODE_UNSIGNED: begin
        rest = i2a_pkg::WORK_W'(mag);
      end
      i2a_pkg::MODE_RADIX: begin
        rest     = i2a_pkg::WORK_W'(mag);
        by_table = 1'b1;
        if (radix_q < i2a_pkg::RADIX_MIN) begin
          base = i2a_pkg::WORK_W'(i2a_pkg::RADIX_MIN);
        end else if (radix_q > i2a_pkg::RADIX_MAX_DEF) begin
          base = i2a_pkg::WORK_W'(i2a_pkg::RADIX_MAX_DEF);
        end else begin
          base = i2a_pkg::WORK_W'(radix_q);
        end
      end
      default: begin
        rest = num[i2a_pkg::WORK_W-1:0];
      end
    endcase
    if (mode == i2a_pkg::MODE_POINTER && rest == '0) begin
      text = '{i2a_pkg::ASCII_LPAREN, i2a_pkg::ASCII_N, i2a_pkg::ASCII_I,
               i2a_pkg::ASCII_L, i2a_pkg::ASCII_RPAREN};
    end else if (mode == i2a_pkg::MODE_POINTER) begin
      text.push_back(i2a_pkg::ASCII_ZERO);
      text.push_back(i2a_pkg::ASCII_X);
      repeat (i2a_pkg::ADDR_DIGITS_DEF) begin
        digs.push_front(glyph(rest[3:0]));
        rest = rest >> 4;
      end
    end else begin
      do begin
        d    = rest % base;
        rest = rest / base;
        digs.push_front(by_table ? glyph(d[3:0])
                                 : i2a_pkg::CHAR_W'(i2a_pkg::ASCII_ZERO + d[3:0]));
      end while (rest != '0 && digs.size() < i2a_pkg::MAX_DIGITS_DEF);
    end
    foreach (digs[i]) text.push_back(digs[i]);
    foreach (text[i]) pending_chars.push_back('{text[i], i == text.size() - 1});
  endfunction

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic put_number(input logic [i2a_pkg::ACTION_W-1:0] mode,
                            input logic [i2a_pkg::VALUE_W-1:0]  num,
                            input string                        txt);
    int gap;
    gap = draw_gap(in_calm);
    cfg_ch.valid <= 1'b0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= mode;
    in_ch.value  <= num;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    numbers_sent++;
    if (txt.len() > 0) begin
      for (int i = 0; i < txt.len(); i++) begin
        pending_chars.push_back('{txt[i], i == txt.len() - 1});
      end
    end else begin
      format_number(mode, num);
    end
  endtask

  task automatic write_reg(input logic [i2a_pkg::CFG_IDX_W-1:0] idx,
                           input logic [i2a_pkg::CFG_DAT_W-1:0] dat);
    int gap;
    in_ch.valid <= 1'b0;
    wait_drained();
    gap = draw_gap(cfg_calm);
    if (gap > 0) begin
      cfg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= dat;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_writes++;
    case (idx)
      i2a_pkg::REG_RADIX:    radix_q   = dat[i2a_pkg::RADIX_W-1:0];
      i2a_pkg::REG_CHARS_LO: glyphs_lo = dat;
      i2a_pkg::REG_CHARS_HI: glyphs_hi = dat;
      default: ;
    endcase
  endtask

  // character sink and checker
  initial begin
    int         gap;
    int         calm;
    char_beat_t want;
    calm = 0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = draw_gap(calm);
      if (!held_off && beats_seen >= HOLD_AT) begin
        gap      = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
      beats_seen++;
      if (pending_chars.size() == 0) begin
        $error("char_out: expected none, got %h (last %b)", out_ch.char_out, out_ch.last);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_ch.char_out !== want.chr) begin
          $error("char_out: expected %h, got %h", want.chr, out_ch.char_out);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [i2a_pkg::ACTION_W-1:0]  mode;
    logic [31:0]                   hi;
    logic [31:0]                   lo;
    logic [i2a_pkg::RADIX_W-1:0]   rdx;
    logic [i2a_pkg::CFG_DAT_W-1:0] tbl_lo;
    logic [i2a_pkg::CFG_DAT_W-1:0] tbl_hi;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= i2a_pkg::MODE_SIGNED;
    in_ch.value  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= i2a_pkg::REG_RADIX;
    cfg_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_write) write_reg(plan[i].code, plan[i].data);
      else put_number(plan[i].code, plan[i].data, plan[i].text);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      rdx = (phase < 6) ? radix_corners[phase]
                        : i2a_pkg::RADIX_W'($urandom_range(0, 31));
      if (phase == 0) begin
        tbl_lo = '1;
        tbl_hi = '1;
      end else if (phase == 1) begin
        tbl_lo = '0;
        tbl_hi = '0;
      end else begin
        tbl_lo = {$urandom, $urandom};
        tbl_hi = {$urandom, $urandom};
      end
      write_reg(i2a_pkg::REG_RADIX, i2a_pkg::CFG_DAT_W'(rdx));
      write_reg(i2a_pkg::REG_CHARS_LO, tbl_lo);
      write_reg(i2a_pkg::REG_CHARS_HI, tbl_hi);
      repeat (PHASE_ITEMS) begin
        mode = i2a_pkg::ACTION_W'($urandom_range(0, 3));
        hi   = $urandom;
        lo   = $urandom;
        case ($urandom_range(0, 7))
          0: lo = $urandom_range(0, 9);
          1: lo = $urandom_range(0, 1000);
          2: lo = 32'hFFFF_FFFF - $urandom_range(0, 15);
          3: lo = 32'h8000_0000 + $urandom_range(0, 15);
          4: begin
            hi[15:0] = '0;
            lo       = '0;
          end
          default: ;
        endcase
        put_number(mode, {hi, lo}, "");
      end
    end

    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    wait_drained();
    repeat (32) @(posedge clk);

    $display("Formatted %0d numbers into %0d characters with %0d register writes",
             numbers_sent, beats_seen, reg_writes);
    $display("Covered all four modes, radix clamping, nil pointers and a %0d-cycle sink hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
